>>> hw/rtl/bpls_pkg.sv
// Shared types and constants for the budgeted prize label search block.
package bpls_pkg;

  localparam int MAX_NODES   = 8;
  localparam int QUEUE_DEPTH = 64;

  localparam logic [1:0] CMD_LOAD_DIST  = 2'd0;
  localparam logic [1:0] CMD_LOAD_PRIZE = 2'd1;
  localparam logic [1:0] CMD_RUN        = 2'd2;

  localparam logic CFG_NODE_COUNT  = 1'b0;
  localparam logic CFG_TIME_BUDGET = 1'b1;

  localparam int TIME_W  = 16;
  localparam int PRIZE_W = 12;
  localparam int MASK_W  = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_POP,
    ST_QWAIT,
    ST_RD,
    ST_EVAL,
    ST_EMIT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic init;      // reset labels and queue, push node 0
    logic pop;       // read queue head
    logic latch;     // capture the popped label
    logic rd;        // read distance and prize for the node under test
    logic eval;      // compare and update the node under test
    logic node_clr;  // node index to zero
    logic node_inc;  // node index plus one
    logic emit;      // load output register for the current node
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic q_empty;
    logic node_last;
    logic out_free;
  } dp_sts_t;

endpackage

>>> hw/rtl/bpls_ctrl.sv
// Sequencing state machine of the label search.
module bpls_ctrl import bpls_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    run_start,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (run_start) state_nxt = ST_INIT;
      ST_INIT:  state_nxt = ST_POP;
      ST_POP:   state_nxt = sts.q_empty ? ST_EMIT : ST_QWAIT;
      ST_QWAIT: state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_EVAL;
      ST_EVAL:  state_nxt = sts.node_last ? ST_POP : ST_RD;
      ST_EMIT:  if (sts.out_free) state_nxt = sts.node_last ? ST_IDLE : ST_EMIT;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE:  ;
      ST_INIT:  cmd.init = 1'b1;
      ST_POP: begin
        cmd.pop = !sts.q_empty;
        cmd.node_clr = 1'b1;
      end
      ST_QWAIT: cmd.latch = 1'b1;
      ST_RD:    cmd.rd = 1'b1;
      ST_EVAL: begin
        cmd.eval = 1'b1;
        cmd.node_inc = !sts.node_last;
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
        cmd.node_inc = sts.out_free && !sts.node_last;
        cmd.node_clr = sts.out_free && sts.node_last;
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/bpls_dpath.sv
// Tables, label store, label queue and output register of the label search.
module bpls_dpath import bpls_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 ld_dist,
  input  logic                 ld_prize,
  input  logic [2:0]           ld_row,
  input  logic [2:0]           ld_col,
  input  logic [7:0]           ld_value,
  input  logic [3:0]           node_count,
  input  logic [TIME_W-1:0]    time_budget,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_node,
  output logic [TIME_W-1:0]    out_time,
  output logic [PRIZE_W-1:0]   out_prize,
  output logic [MASK_W-1:0]    out_mask,
  output logic                 out_ovf,
  output logic                 out_last
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int LW = NW + TIME_W + PRIZE_W + MAX_NODES;

  logic [7:0] dist_mem [MAX_NODES*MAX_NODES];
  logic [7:0] prize_tab [MAX_NODES];
  logic [LW-1:0] q_mem [QUEUE_DEPTH];

  logic [TIME_W-1:0]    best_time_r  [MAX_NODES];
  logic [PRIZE_W-1:0]   best_prize_r [MAX_NODES];
  logic [MAX_NODES-1:0] best_mask_r  [MAX_NODES];

  logic [QW-1:0] q_head_r, q_tail_r;
  logic [QW:0]   q_count_r;
  logic          ovf_r;
  logic [NW-1:0] node_r;
  logic [NW:0]   n_use;

  logic [LW-1:0]        q_rd_r;
  logic [NW-1:0]        c_node_r;
  logic [TIME_W-1:0]    c_time_r;
  logic [PRIZE_W-1:0]   c_prize_r;
  logic [MAX_NODES-1:0] c_mask_r;
  logic [7:0]           d_rd_r, p_rd_r;

  always_comb begin
    if (node_count == 4'd0) n_use = (NW+1)'(1);
    else if ({28'd0, node_count} > MAX_NODES) n_use = (NW+1)'(MAX_NODES);
    else n_use = (NW+1)'(node_count);
  end

  assign sts.q_empty   = (q_count_r == '0);
  assign sts.node_last = ({1'b0, node_r} == n_use - (NW+1)'(1));
  assign sts.out_free  = !out_valid || out_ready;

  // Table loads.
  always_ff @(posedge clk) begin
    if (ld_dist && {29'd0, ld_row} < MAX_NODES && {29'd0, ld_col} < MAX_NODES)
      dist_mem[{NW'(ld_row), NW'(ld_col)}] <= ld_value;
    if (cmd.rd) d_rd_r <= dist_mem[{node_r, c_node_r}];
  end

  always_ff @(posedge clk) begin
    if (ld_prize && {29'd0, ld_row} < MAX_NODES) prize_tab[NW'(ld_row)] <= ld_value;
    if (cmd.rd) p_rd_r <= prize_tab[node_r];
  end

  // Candidate arithmetic for the node under test.
  logic [PRIZE_W:0] np;
  logic [TIME_W:0]  nt;
  logic             take;
  always_comb begin
    np = {1'b0, c_prize_r} + (PRIZE_W+1)'(p_rd_r);
    nt = {1'b0, c_time_r} + (TIME_W+1)'(d_rd_r);
    take = !c_mask_r[node_r] && (np[PRIZE_W-1:0] > best_prize_r[node_r])
           && (nt <= {1'b0, time_budget});
  end

  logic [MAX_NODES-1:0] new_mask;
  assign new_mask = c_mask_r | (MAX_NODES'(1) << node_r);

  logic             push;
  logic [LW-1:0]    push_data;
  always_comb begin
    push = 1'b0;
    push_data = {NW'(0), TIME_W'(0), PRIZE_W'(0), MAX_NODES'(1)};
    if (cmd.init) push = 1'b1;
    else if (cmd.eval && take) begin
      push = 1'b1;
      push_data = {node_r, nt[TIME_W-1:0], np[PRIZE_W-1:0], new_mask};
    end
  end

  // Label store.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_NODES; i++) begin
      if (!rst_n) begin
        best_time_r[i]  <= '0;
        best_prize_r[i] <= '0;
        best_mask_r[i]  <= '0;
      end else if (cmd.init) begin
        best_time_r[i]  <= '0;
        best_prize_r[i] <= '0;
        best_mask_r[i]  <= MAX_NODES'(1) << i;
      end else if (cmd.eval && take && node_r == NW'(i)) begin
        best_time_r[i]  <= nt[TIME_W-1:0];
        best_prize_r[i] <= np[PRIZE_W-1:0];
        best_mask_r[i]  <= new_mask;
      end
    end
  end

  // Label queue.
  always_ff @(posedge clk) begin
    if (push && (cmd.init || q_count_r != (QW+1)'(QUEUE_DEPTH)))
      q_mem[cmd.init ? QW'(0) : q_tail_r] <= push_data;
    if (cmd.pop) q_rd_r <= q_mem[q_head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_head_r  <= '0;
      q_tail_r  <= '0;
      q_count_r <= '0;
      ovf_r     <= 1'b0;
    end else if (cmd.init) begin
      q_head_r  <= '0;
      q_tail_r  <= QW'(1);
      q_count_r <= (QW+1)'(1);
      ovf_r     <= 1'b0;
    end else begin
      if (cmd.pop) q_head_r <= q_head_r + QW'(1);
      if (push) begin
        if (q_count_r == (QW+1)'(QUEUE_DEPTH)) ovf_r <= 1'b1;
        else q_tail_r <= q_tail_r + QW'(1);
      end
      q_count_r <= q_count_r - (QW+1)'(cmd.pop)
                 + (QW+1)'(push && q_count_r != (QW+1)'(QUEUE_DEPTH));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) {c_node_r, c_time_r, c_prize_r, c_mask_r} <= q_rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) node_r <= '0;
    else if (cmd.node_clr) node_r <= '0;
    else if (cmd.node_inc) node_r <= node_r + NW'(1);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_node  <= 3'(node_r);
      out_time  <= best_time_r[node_r];
      out_prize <= best_prize_r[node_r];
      out_mask  <= MASK_W'(best_mask_r[node_r]);
      out_ovf   <= ovf_r;
      out_last  <= sts.node_last;
    end
  end

endmodule

>>> hw/rtl/budgeted_prize_label_search.sv
// Top level of the budgeted prize label search block.
// Load items (distance and prize) are taken one per cycle. A run item starts
// a breadth-first label search from node 0 and holds off the input until the
// last result is loaded into the output register. The search has an init
// state, then a pop and a latch state for each queued label plus a read and
// an evaluate state per node in use for every popped label, set by the single
// distance memory read port and the shared compare unit, and a last pop state
// to find the queue empty; then one result per node leaves at one per cycle
// while the output side is ready. The queue keeps QUEUE_DEPTH labels; further
// pushes are dropped and flagged in the overflow bit. Entries of the distance
// and prize tables read before being loaded give undefined results.
module budgeted_prize_label_search import bpls_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // command[1:0]
  input  logic [15:0] in_tdata,   // row[2:0], col[5:3], value[13:6]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // node_id[2:0], arrival_time[18:3],
                                  // total_prize[30:19], visited_mask[38:31]
  output logic        out_tuser,  // overflow[0]
  output logic        out_tlast
);

  logic [3:0]        node_count_r;
  logic [TIME_W-1:0] time_budget_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r  <= 4'd5;
      time_budget_r <= 16'd9;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NODE_COUNT:  node_count_r  <= cfg_data[3:0];
        CFG_TIME_BUDGET: time_budget_r <= cfg_data;
        default: ;
      endcase
    end
  end

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    busy, acc;
  logic [1:0] command;

  assign command   = in_tuser;
  assign in_tready = !busy;
  assign acc       = in_tvalid && in_tready;

  logic [2:0]         o_node;
  logic [TIME_W-1:0]  o_time;
  logic [PRIZE_W-1:0] o_prize;
  logic [MASK_W-1:0]  o_mask;

  bpls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .run_start (acc && command == CMD_RUN),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  bpls_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ld_dist     (acc && command == CMD_LOAD_DIST),
    .ld_prize    (acc && command == CMD_LOAD_PRIZE),
    .ld_row      (in_tdata[2:0]),
    .ld_col      (in_tdata[5:3]),
    .ld_value    (in_tdata[13:6]),
    .node_count  (node_count_r),
    .time_budget (time_budget_r),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_node    (o_node),
    .out_time    (o_time),
    .out_prize   (o_prize),
    .out_mask    (o_mask),
    .out_ovf     (out_tuser),
    .out_last    (out_tlast)
  );

  assign out_tdata = {1'b0, o_mask, o_prize, o_time, o_node};

endmodule

>>> test/budgeted_prize_label_search_checker.sv
// Checker for the budgeted prize label search block: predicts every run and compares results.
module budgeted_prize_label_search_checker import bpls_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [1:0]  in_tuser,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          labels_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  node;
    logic [15:0] arrival;
    logic [11:0] prize;
    logic [7:0]  mask;
    logic        ovf;
    logic        last;
  } node_label_t;

  node_label_t expected_labels[$];

  logic [3:0]  node_count;
  logic [15:0] time_budget;
  logic [7:0]  dist_mem[64];
  logic [7:0]  prize_mem[8];
  int best_t[8];
  int best_p[8];
  int best_m[8];
  int fifo_node[64];
  int fifo_t[64];
  int fifo_p[64];
  int fifo_m[64];
  int fifo_head;
  int fifo_cnt;
  bit fifo_ovf;

  assign labels_pending = expected_labels.size();

  initial fail_count = 0;

  task automatic push_label(input int node);
    int slot;
    if (fifo_cnt >= 64) begin
      fifo_ovf = 1;
    end else begin
      slot = (fifo_head + fifo_cnt) % 64;
      fifo_node[slot] = node;
      fifo_t[slot] = best_t[node];
      fifo_p[slot] = best_p[node];
      fifo_m[slot] = best_m[node];
      fifo_cnt++;
    end
  endtask

  // Breadth-first label search from node 0; appends one label per node in use.
  task automatic search_labels();
    int n, i, cid, ct, cp, cm, np, nt;
    node_label_t r;
    n = (node_count == 0) ? 1 : ((node_count > 8) ? 8 : int'(node_count));
    for (i = 0; i < 8; i++) begin
      best_t[i] = 0;
      best_p[i] = 0;
      best_m[i] = 1 << i;
    end
    fifo_head = 0;
    fifo_cnt = 0;
    fifo_ovf = 0;
    push_label(0);
    while (fifo_cnt > 0) begin
      cid = fifo_node[fifo_head];
      ct = fifo_t[fifo_head];
      cp = fifo_p[fifo_head];
      cm = fifo_m[fifo_head];
      fifo_head = (fifo_head + 1) % 64;
      fifo_cnt--;
      for (i = 0; i < n; i++) begin
        np = cp + prize_mem[i];
        nt = ct + dist_mem[i * 8 + cid];
        if (((cm >> i) & 1) == 0 && np > best_p[i] && nt <= time_budget) begin
          best_m[i] = cm | (1 << i);
          best_t[i] = nt;
          best_p[i] = np;
          push_label(i);
        end
      end
    end
    for (i = 0; i < n; i++) begin
      r.node = i[2:0];
      r.arrival = best_t[i][15:0];
      r.prize = best_p[i][11:0];
      r.mask = best_m[i][7:0];
      r.ovf = fifo_ovf;
      r.last = (i == n - 1);
      expected_labels.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    node_label_t want, got;
    if (!rst_n) begin
      node_count <= 4'd5;
      time_budget <= 16'd9;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_NODE_COUNT) node_count <= cfg_data[3:0];
        else time_budget <= cfg_data;
      end
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          CMD_LOAD_DIST:  dist_mem[in_tdata[2:0] * 8 + in_tdata[5:3]] = in_tdata[13:6];
          CMD_LOAD_PRIZE: prize_mem[in_tdata[2:0]] = in_tdata[13:6];
          CMD_RUN:        search_labels();
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[2:0], out_tdata[18:3], out_tdata[30:19], out_tdata[38:31],
               out_tuser, out_tlast};
        if (expected_labels.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("Unexpected result item: %h", got);
        end else begin
          want = expected_labels.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"Mismatch node %0d/%0d time %0d/%0d prize %0d/%0d ",
                        "mask %h/%h ovf %b/%b last %b/%b (expected/actual)"},
                       want.node, got.node, want.arrival, got.arrival,
                       want.prize, got.prize, want.mask, got.mask,
                       want.ovf, got.ovf, want.last, got.last);
          end
        end
      end
    end
  end

endmodule

>>> test/budgeted_prize_label_search_tb.sv
// Testbench top for the budgeted prize label search block: stimulus and verdict.
module budgeted_prize_label_search_tb import bpls_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  int          fail_count;
  int          labels_pending;

  // Idle percentages of the two sides; changed by the stimulus between phases.
  int tx_idle = 0;
  int rx_idle = 0;
  // Set by the stimulus to make the receiver hold off for a long stretch.
  bit rx_hold_req = 0;
  int cycles = 0;

  budgeted_prize_label_search dut (.*);

  budgeted_prize_label_search_checker chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The run is cut off if it hangs and is then reported as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 0;
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  // Offers one item; valid stays high after acceptance so back-to-back items
  // never see valid dropped and raised in the same step.
  task automatic send_item(input logic [1:0] cmd, input logic [2:0] row,
                           input logic [2:0] col, input logic [7:0] value);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {2'b00, value, col, row};
    do @(posedge clk); while (!in_tready);
  endtask

  // Waits until every expected result has left and the block has settled.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (labels_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic index, input logic [15:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [15:0] nodes, input logic [15:0] budget);
    drain();
    write_reg(CFG_NODE_COUNT, nodes);
    write_reg(CFG_TIME_BUDGET, budget);
  endtask

  function automatic logic [7:0] rand_value();
    // Mostly short hops so that the budget actually decides the search.
    return ($urandom_range(1) == 0) ? 8'($urandom_range(15)) : 8'($urandom);
  endfunction

  // A well-formed sequence: a few table loads, then a run; sometimes noise.
  task automatic random_sequence(output int count);
    int k, loads;
    loads = $urandom_range(6);
    for (k = 0; k < loads; k++) begin
      if ($urandom_range(9) == 0)
        send_item(2'd3, 3'($urandom), 3'($urandom), 8'($urandom));
      else if ($urandom_range(3) == 0)
        send_item(CMD_LOAD_PRIZE, 3'($urandom), 3'($urandom), rand_value());
      else
        send_item(CMD_LOAD_DIST, 3'($urandom), 3'($urandom), rand_value());
    end
    send_item(CMD_RUN, 3'($urandom), 3'($urandom), 8'($urandom));
    count = loads + 1;
  endtask

  function automatic logic [15:0] rand_budget();
    case ($urandom_range(3))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(60));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int r, c, phase, items_sent, seq_items;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Every table entry is loaded first, so no run can read an unwritten one.
    for (r = 0; r < 8; r++) begin
      for (c = 0; c < 8; c++) send_item(CMD_LOAD_DIST, r[2:0], c[2:0], rand_value());
      send_item(CMD_LOAD_PRIZE, r[2:0], 3'($urandom), 8'($urandom_range(1, 255)));
    end

    // Directed part: reset settings, command three, extreme values and sizes.
    send_item(2'd3, 3'd7, 3'd7, 8'hFF);
    send_item(CMD_RUN, 3'd0, 3'd0, 8'd0);
    send_item(CMD_LOAD_DIST, 3'd7, 3'd7, 8'hFF);
    send_item(CMD_LOAD_DIST, 3'd0, 3'd0, 8'h00);
    send_item(CMD_LOAD_PRIZE, 3'd7, 3'd0, 8'hFF);
    send_item(CMD_LOAD_PRIZE, 3'd0, 3'd7, 8'h00);
    configure(16'd1, 16'd100);
    send_item(CMD_RUN, 3'd7, 3'd7, 8'hFF);
    configure(16'd8, 16'hFFFF);
    send_item(CMD_RUN, 3'd0, 3'd0, 8'd0);
    configure(16'd0, 16'd50);
    send_item(CMD_RUN, 3'd0, 3'd0, 8'd0);
    configure(16'hFFFF, 16'd0);
    send_item(CMD_RUN, 3'd0, 3'd0, 8'd0);
    configure(16'd9, 16'd30);
    send_item(CMD_RUN, 3'd0, 3'd0, 8'd0);
    // Zero distances and large prizes everywhere with an open budget fill the queue.
    for (r = 0; r < 8; r++) begin
      send_item(CMD_LOAD_PRIZE, r[2:0], 3'd0, 8'd255 - 8'(r));
      for (c = 0; c < 8; c++) send_item(CMD_LOAD_DIST, r[2:0], c[2:0], 8'd0);
    end
    configure(16'd8, 16'hFFFF);
    send_item(CMD_RUN, 3'd0, 3'd0, 8'd0);

    // Random part in three idling phases.
    for (phase = 0; phase < 3; phase++) begin
      drain();
      tx_idle = (phase == 0) ? 17 : ((phase == 1) ? 88 : 0);
      rx_idle = (phase == 0) ? 88 : ((phase == 1) ? 17 : 0);
      if (phase == 2) rx_hold_req = 1;
      items_sent = 0;
      while (items_sent < 58) begin
        if ($urandom_range(7) == 0) begin
          configure(16'($urandom_range(15)), rand_budget());
        end
        random_sequence(seq_items);
        items_sent += seq_items;
      end
    end

    // End: all expectations in, then a settling stretch.
    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
